[rtl/core/bmpx_pkg.sv]
// bmpx_pkg: shared types and constants for the 24-bit BMP pixel extractor.
// No dependencies; compiled first.
package bmpx_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int POS_W     = 32;
   localparam int INDEX_W   = 24;
   localparam int BYTE_W    = 8;

   localparam logic [POS_W-1:0] HEADER_BYTES = 32'd54;
   localparam logic [POS_W-1:0] LAST_HDR_POS = HEADER_BYTES - 32'd1;
   localparam logic [POS_W-1:0] SIG_POS      = 32'd1;
   localparam logic [POS_W-1:0] OFFSET_POS   = 32'd10;
   localparam logic [POS_W-1:0] WIDTH_POS    = 32'd18;
   localparam logic [POS_W-1:0] HEIGHT_POS   = 32'd22;
   localparam logic [POS_W-1:0] BPP_POS      = 32'd28;
   localparam logic [POS_W-1:0] MAX_DIM_VAL  = POS_W'(MAX_DIM);

   localparam logic [15:0]       BPP_24 = 16'd24;
   localparam logic [BYTE_W-1:0] SIG_B  = 8'h42;
   localparam logic [BYTE_W-1:0] SIG_M  = 8'h4D;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SKIP,
      PH_DATA,
      PH_PAD,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      ST_PIXEL     = 2'd0,
      ST_BAD_SIG   = 2'd1,
      ST_BAD_DEPTH = 2'd2,
      ST_BAD_SIZE  = 2'd3
   } status_type;

   // control from the sequencer to the header capture
   typedef struct packed {
      logic clear;
      logic load;
      logic count;
   } hdr_ctl_type;

   // header fields and checks seen by the sequencer
   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   pos_inc;
      logic [POS_W-1:0]   data_offset;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic               bpp_ok;
      logic               dims_ok;
      logic [BYTE_W-1:0]  first_byte;
      logic [INDEX_W-1:0] row_base_init;
   } hdr_info_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] pixel_index;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic               last_pixel;
   } rsp_data_type;

endpackage

[rtl/core/bmpx_req_if.sv]
// bmpx_req_if: byte stream channel into the extractor.
// Depends on bmpx_pkg.
interface bmpx_req_if;
   logic                        valid;
   logic                        ready;
   logic [bmpx_pkg::BYTE_W-1:0] file_byte;
   logic                        start_req;

   modport source (output valid, output file_byte, output start_req, input ready);
   modport sink   (input valid, input file_byte, input start_req, output ready);
endinterface

[rtl/core/bmpx_rsp_if.sv]
// bmpx_rsp_if: pixel / error result channel out of the extractor.
// Depends on bmpx_pkg.
interface bmpx_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [bmpx_pkg::INDEX_W-1:0] pixel_index;
   logic [bmpx_pkg::BYTE_W-1:0]  red;
   logic [bmpx_pkg::BYTE_W-1:0]  green;
   logic [bmpx_pkg::BYTE_W-1:0]  blue;
   logic                         last_pixel;

   modport source (output valid, output status, output pixel_index, output red,
                   output green, output blue, output last_pixel, input ready);
   modport sink   (input valid, input status, input pixel_index, input red,
                   input green, input blue, input last_pixel, output ready);
endinterface

[rtl/core/bmp24_pixel_extractor_core.sv]
// bmp24_pixel_extractor_core: top level of the 24-bit BMP pixel extractor.
// Depends on bmpx_pkg, bmpx_req_if, bmpx_rsp_if, bmpx_hdr and bmpx_seq.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        file_byte[7:0], start_req
//   rsp_chan  out  valid/ready        status[1:0], pixel_index[23:0],
//                                     red, green, blue[7:0], last_pixel
//
// One byte per cycle sustained while the result channel is not stalled.
// A byte is held in the input register; its result goes to the result register.
// Synchronous active-high reset puts the sequencer in idle; bytes without
// start_req are dropped until a start. A stalled result holds the input
// register; the input register drains whenever the result register is
// empty or being taken, so back-to-back transactions flow without bubbles.
module bmp24_pixel_extractor_core (
   input logic      clock,
   input logic      reset,
   bmpx_req_if.sink   req_chan,
   bmpx_rsp_if.source rsp_chan
);
   import bmpx_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_start_ff, in_start_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   rsp_data_type      out_data_ff, out_data_in;

   logic              advance;
   logic              res_valid;
   rsp_data_type      res;
   hdr_ctl_type       hdr_ctl;
   hdr_info_type      hdr_info;

   // a byte moves on when the result register can take whatever it makes
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.file_byte;
         in_start_in = req_chan.start_req;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = res_valid;
         out_data_in  = res;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      out_data_ff <= out_data_in;
   end

   // header capture: byte position, offset, width, height, depth
   bmpx_hdr u_hdr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hdr_ctl),
      .byte_in (in_byte_ff),
      .info    (hdr_info)
   );

   // phase sequencer: checks, skip, BGR assembly, padding, flipped index
   bmpx_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .start     (in_start_ff),
      .byte_in   (in_byte_ff),
      .info      (hdr_info),
      .ctl       (hdr_ctl),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_data_ff.status;
   assign rsp_chan.pixel_index = out_data_ff.pixel_index;
   assign rsp_chan.red         = out_data_ff.red;
   assign rsp_chan.green       = out_data_ff.green;
   assign rsp_chan.blue        = out_data_ff.blue;
   assign rsp_chan.last_pixel  = out_data_ff.last_pixel;

   a_error_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status != ST_PIXEL) |->
         (out_data_ff.pixel_index == '0 && out_data_ff.last_pixel == 1'b0))
      else $error("error transaction carries pixel fields");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> out_valid_ff)
      else $error("pending result transaction lost");

endmodule

[rtl/core/bmpx_hdr.sv]
// bmpx_hdr: byte position counter and little-endian header field capture.
// Depends on bmpx_pkg.
module bmpx_hdr (
   input  logic                        clock,
   input  logic                        reset,
   input  bmpx_pkg::hdr_ctl_type       ctl,
   input  logic [bmpx_pkg::BYTE_W-1:0] byte_in,
   output bmpx_pkg::hdr_info_type      info
);
   import bmpx_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in, pos_cur, pos_inc;
   logic [POS_W-1:0]  offset_ff, offset_in;
   logic [POS_W-1:0]  width_ff, width_in;
   logic [POS_W-1:0]  height_ff, height_in;
   logic [15:0]       bpp_ff, bpp_in;
   logic [BYTE_W-1:0] first_ff, first_in;
   logic [1:0]        lane;
   logic              width_ok, height_ok;
   logic [DIM_W-1:0]  height_m1;
   logic [2*DIM_W-1:0] base_prod;

   always_comb begin
      pos_cur   = ctl.clear ? '0 : pos_ff;
      pos_inc   = pos_cur + 32'd1;
      // the 4-byte fields start at byte 2 mod 4, so lane = (pos - 2) mod 4
      lane      = pos_cur[1:0] - 2'd2;
      offset_in = ctl.clear ? '0 : offset_ff;
      width_in  = ctl.clear ? '0 : width_ff;
      height_in = ctl.clear ? '0 : height_ff;
      bpp_in    = ctl.clear ? '0 : bpp_ff;
      first_in  = first_ff;
      if (ctl.load) begin
         if (pos_cur == '0) begin
            first_in = byte_in;
         end else if (pos_cur >= OFFSET_POS && pos_cur <= OFFSET_POS + 32'd3) begin
            offset_in[{lane, 3'b000} +: BYTE_W] = byte_in;
         end else if (pos_cur >= WIDTH_POS && pos_cur <= WIDTH_POS + 32'd3) begin
            width_in[{lane, 3'b000} +: BYTE_W] = byte_in;
         end else if (pos_cur >= HEIGHT_POS && pos_cur <= HEIGHT_POS + 32'd3) begin
            height_in[{lane, 3'b000} +: BYTE_W] = byte_in;
         end else if (pos_cur >= BPP_POS && pos_cur <= BPP_POS + 32'd1) begin
            bpp_in[{pos_cur[0], 3'b000} +: BYTE_W] = byte_in;
         end
      end
      pos_in = ctl.count ? pos_inc : pos_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      bpp_ff    <= bpp_in;
      first_ff  <= first_in;
   end

   // signed 32-bit dimension: positive and no larger than MAX_DIM
   assign width_ok  = !width_ff[POS_W-1] && (width_ff != '0) && (width_ff <= MAX_DIM_VAL);
   assign height_ok = !height_ff[POS_W-1] && (height_ff != '0) && (height_ff <= MAX_DIM_VAL);

   assign height_m1 = height_ff[DIM_W-1:0] - DIM_W'(1);
   assign base_prod = height_m1 * width_ff[DIM_W-1:0];

   always_comb begin
      info.pos           = pos_cur;
      info.pos_inc       = pos_inc;
      info.data_offset   = offset_ff;
      info.width         = width_ff[DIM_W-1:0];
      info.height        = height_ff[DIM_W-1:0];
      info.bpp_ok        = (bpp_ff == BPP_24);
      info.dims_ok       = width_ok && height_ok;
      info.first_byte    = first_ff;
      info.row_base_init = base_prod[INDEX_W-1:0];
   end

endmodule

[rtl/core/bmpx_seq.sv]
// bmpx_seq: phase sequencer, pixel assembly and row/column counters.
// Depends on bmpx_pkg; drives bmpx_hdr through hdr_ctl_type.
module bmpx_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        start,
   input  logic [bmpx_pkg::BYTE_W-1:0] byte_in,
   input  bmpx_pkg::hdr_info_type      info,
   output bmpx_pkg::hdr_ctl_type       ctl,
   output logic                        res_valid,
   output bmpx_pkg::rsp_data_type      res
);
   import bmpx_pkg::*;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [DIM_W-1:0]   row_ff, row_in, row_cur;
   logic [DIM_W-1:0]   col_ff, col_in, col_cur, col_inc;
   logic [1:0]         chan_ff, chan_in, chan_cur;
   logic [1:0]         pad_ff, pad_in, pad_cur, pad_dec;
   logic [BYTE_W-1:0]  blue_ff, blue_in;
   logic [BYTE_W-1:0]  green_ff, green_in;
   logic [INDEX_W-1:0] base_ff, base_in;
   logic               last;
   logic               sig_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         chan_ff  <= '0;
         pad_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         chan_ff  <= chan_in;
         pad_ff   <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
      base_ff  <= base_in;
   end

   always_comb begin
      phase_cur = (step && start) ? PH_HEADER : phase_ff;
      row_cur   = (step && start) ? '0 : row_ff;
      col_cur   = (step && start) ? '0 : col_ff;
      chan_cur  = (step && start) ? '0 : chan_ff;
      pad_cur   = (step && start) ? '0 : pad_ff;
      col_inc   = col_cur + DIM_W'(1);
      pad_dec   = pad_cur - 2'd1;
      last      = (row_cur + DIM_W'(1) == info.height) && (col_inc == info.width);
      sig_ok    = (info.first_byte == SIG_B) && (byte_in == SIG_M);

      phase_in  = phase_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      chan_in   = chan_ff;
      pad_in    = pad_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      base_in   = base_ff;

      ctl.clear = step && start;
      ctl.load  = 1'b0;
      ctl.count = 1'b0;

      res_valid       = 1'b0;
      res.status      = ST_PIXEL;
      res.pixel_index = '0;
      res.red         = '0;
      res.green       = '0;
      res.blue        = '0;
      res.last_pixel  = 1'b0;

      if (step) begin
         phase_in = phase_cur;
         row_in   = row_cur;
         col_in   = col_cur;
         chan_in  = chan_cur;
         pad_in   = pad_cur;
         unique case (phase_cur)
            PH_HEADER: begin
               ctl.load  = 1'b1;
               ctl.count = 1'b1;
               if (info.pos == SIG_POS && !sig_ok) begin
                  res_valid  = 1'b1;
                  res.status = ST_BAD_SIG;
                  phase_in   = PH_HALT;
               end else if (info.pos == LAST_HDR_POS) begin
                  if (!info.bpp_ok) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD_DEPTH;
                     phase_in   = PH_HALT;
                  end else if (!info.dims_ok) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD_SIZE;
                     phase_in   = PH_HALT;
                  end else begin
                     base_in = info.row_base_init;
                     if (!info.data_offset[POS_W-1] && info.data_offset > HEADER_BYTES) begin
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
            PH_SKIP: begin
               ctl.count = 1'b1;
               if (info.pos_inc >= info.data_offset) begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               case (chan_cur)
                  2'd0: begin
                     blue_in = byte_in;
                     chan_in = 2'd1;
                  end
                  2'd1: begin
                     green_in = byte_in;
                     chan_in  = 2'd2;
                  end
                  default: begin
                     chan_in         = 2'd0;
                     res_valid       = 1'b1;
                     res.pixel_index = base_ff + INDEX_W'(col_cur);
                     res.red         = byte_in;
                     res.green       = green_ff;
                     res.blue        = blue_ff;
                     res.last_pixel  = last;
                     col_in          = col_inc;
                     if (last) begin
                        phase_in = PH_HALT;
                     end else if (col_inc == info.width) begin
                        // row padding to a 4-byte multiple is width mod 4
                        pad_in = info.width[1:0];
                        if (info.width[1:0] != 2'd0) begin
                           phase_in = PH_PAD;
                        end else begin
                           row_in  = row_cur + DIM_W'(1);
                           col_in  = '0;
                           base_in = base_ff - INDEX_W'(info.width);
                        end
                     end
                  end
               endcase
            end
            PH_PAD: begin
               pad_in = pad_dec;
               if (pad_dec == 2'd0) begin
                  row_in   = row_cur + DIM_W'(1);
                  col_in   = '0;
                  base_in  = base_ff - INDEX_W'(info.width);
                  phase_in = PH_DATA;
               end
            end
            PH_IDLE, PH_HALT: begin
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   a_last_halts : assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.last_pixel) |=> (phase_ff == PH_HALT))
      else $error("last pixel did not halt the sequencer");

   a_error_halts : assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status != ST_PIXEL) |=> (phase_ff == PH_HALT))
      else $error("error result did not halt the sequencer");

   a_pad_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAD) |-> (pad_ff != 2'd0))
      else $error("padding phase with zero count");

   a_col_in_row : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (col_ff < info.width))
      else $error("column count past image width in data phase");

endmodule
